>>> src/chip8_instruction_executor_macros.svh
// ---------------------------------------------------------------------------
// CHIP-8 executor assertion macros
// Shared property wrappers clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_EXECUTOR_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_MACROS_SVH

// The property holds at every clock edge outside reset.
`define C8E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define C8E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/c8e_pkg.sv
// ---------------------------------------------------------------------------
// CHIP-8 executor package
// Sizes, the hex font table and the controller-to-datapath command types.
// ---------------------------------------------------------------------------
package c8e_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int STACK_DEPTH   = 16;
  localparam int ADDR_W        = $clog2(MEM_BYTES);
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int SP_W          = $clog2(STACK_DEPTH);
  localparam int SCNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int FONT_BYTES    = 80;

  localparam logic [ADDR_W-1:0] FONT_BASE = ADDR_W'(12'h050);
  localparam logic [ADDR_W-1:0] PC_START  = ADDR_W'(12'h200);

  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_ROW   = 2'd2;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [4:0] {
    DP_IDLE, DP_CLEAR, DP_LATCH, DP_DISPATCH, DP_FETCH_HI, DP_FETCH_LO,
    DP_DECODE, DP_READ_X, DP_READ_Y, DP_EXEC, DP_SPR_RD, DP_SPR_WR,
    DP_SPR_END, DP_BCD, DP_STORE, DP_LOAD_RD, DP_LOAD_WR, DP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [3:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic        clear_done;
    logic        out_busy;
    logic [1:0]  op;
    logic [15:0] ins;
  } stat_t;

endpackage

>>> src/c8e_ctrl.sv
// ---------------------------------------------------------------------------
// CHIP-8 executor controller
// Sequences the clearing pass, fetch, decode and the multi-cycle instructions.
// ---------------------------------------------------------------------------
module c8e_ctrl
  import c8e_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_FETCH_HI, ST_FETCH_LO, ST_DECODE,
    ST_READ_X, ST_READ_Y, ST_EXEC, ST_SPR_RD, ST_SPR_WR, ST_SPR_END,
    ST_BCD, ST_STORE, ST_LOAD_RD, ST_LOAD_WR, ST_FINISH
  } state_e;

  state_e     state_q;
  logic [3:0] cnt_q;
  logic [3:0] ins_x;
  logic [3:0] ins_n;

  assign ins_x = stat_i.ins[11:8];
  assign ins_n = stat_i.ins[3:0];
  assign req_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR:    if (stat_i.clear_done) state_q <= ST_IDLE;
        ST_IDLE:     if (req_valid_i) state_q <= ST_DISPATCH;
        ST_DISPATCH: state_q <= (stat_i.op == OP_EXEC) ? ST_FETCH_HI : ST_FINISH;
        ST_FETCH_HI: state_q <= ST_FETCH_LO;
        ST_FETCH_LO: state_q <= ST_DECODE;
        ST_DECODE:   state_q <= ST_READ_X;
        ST_READ_X:   state_q <= ST_READ_Y;
        ST_READ_Y:   state_q <= ST_EXEC;
        ST_EXEC: begin
          cnt_q <= '0;
          priority if (stat_i.ins[15:12] == 4'hD) begin
            state_q <= (ins_n == 4'd0) ? ST_SPR_END : ST_SPR_RD;
          end else if (stat_i.ins[15:12] == 4'hF && stat_i.ins[7:0] == 8'h33) begin
            state_q <= ST_BCD;
          end else if (stat_i.ins[15:12] == 4'hF && stat_i.ins[7:0] == 8'h55) begin
            state_q <= ST_STORE;
          end else if (stat_i.ins[15:12] == 4'hF && stat_i.ins[7:0] == 8'h65) begin
            state_q <= ST_LOAD_RD;
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_SPR_RD:   state_q <= ST_SPR_WR;
        ST_SPR_WR: begin
          if (cnt_q == ins_n - 4'd1) begin
            state_q <= ST_SPR_END;
          end else begin
            cnt_q   <= cnt_q + 4'd1;
            state_q <= ST_SPR_RD;
          end
        end
        ST_SPR_END:  state_q <= ST_FINISH;
        ST_BCD: begin
          if (cnt_q == 4'd2) state_q <= ST_FINISH;
          cnt_q <= cnt_q + 4'd1;
        end
        ST_STORE: begin
          if (cnt_q == ins_x) state_q <= ST_FINISH;
          cnt_q <= cnt_q + 4'd1;
        end
        ST_LOAD_RD:  state_q <= ST_LOAD_WR;
        ST_LOAD_WR: begin
          if (cnt_q == ins_x) begin
            state_q <= ST_FINISH;
          end else begin
            cnt_q   <= cnt_q + 4'd1;
            state_q <= ST_LOAD_RD;
          end
        end
        ST_FINISH:   if (!stat_i.out_busy) state_q <= ST_IDLE;
        default:     state_q <= ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd_o.cnt = cnt_q;
    unique case (state_q)
      ST_CLEAR:    cmd_o.op = stat_i.clear_done ? DP_IDLE : DP_CLEAR;
      ST_IDLE:     cmd_o.op = req_valid_i ? DP_LATCH : DP_IDLE;
      ST_DISPATCH: cmd_o.op = DP_DISPATCH;
      ST_FETCH_HI: cmd_o.op = DP_FETCH_HI;
      ST_FETCH_LO: cmd_o.op = DP_FETCH_LO;
      ST_DECODE:   cmd_o.op = DP_DECODE;
      ST_READ_X:   cmd_o.op = DP_READ_X;
      ST_READ_Y:   cmd_o.op = DP_READ_Y;
      ST_EXEC:     cmd_o.op = DP_EXEC;
      ST_SPR_RD:   cmd_o.op = DP_SPR_RD;
      ST_SPR_WR:   cmd_o.op = DP_SPR_WR;
      ST_SPR_END:  cmd_o.op = DP_SPR_END;
      ST_BCD:      cmd_o.op = DP_BCD;
      ST_STORE:    cmd_o.op = DP_STORE;
      ST_LOAD_RD:  cmd_o.op = DP_LOAD_RD;
      ST_LOAD_WR:  cmd_o.op = DP_LOAD_WR;
      ST_FINISH:   cmd_o.op = stat_i.out_busy ? DP_IDLE : DP_FINISH;
      default:     cmd_o.op = DP_IDLE;
    endcase
  end

endmodule

>>> src/c8e_datapath.sv
// ---------------------------------------------------------------------------
// CHIP-8 executor datapath
// Memory, registers, stack, display, timers and the result register.
// ---------------------------------------------------------------------------
`include "chip8_instruction_executor_macros.svh"

module c8e_datapath
  import c8e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic [1:0]  in_op_i,
  input  logic [15:0] in_keys_i,
  input  logic [7:0]  in_random_byte_i,
  input  logic [11:0] in_mem_address_i,
  input  logic [7:0]  in_mem_data_i,
  input  logic [4:0]  in_row_select_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] out_program_counter_o,
  output logic [63:0] out_row_pixels_o,
  output logic        out_sound_on_o,
  output logic        out_waiting_key_o,
  output logic        out_stack_error_o
);

  logic [7:0]              mem [MEM_BYTES];
  logic [7:0]              mem_rdata_q;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [ADDR_W-1:0]       mem_raddr;
  logic [7:0]              mem_wdata;

  logic [ADDR_W-1:0]       clr_addr_q;
  logic                    clr_done_q;
  logic [7:0]              font_byte;
  logic [ADDR_W-1:0]       font_off;

  logic [1:0]              op_q;
  logic [15:0]             keys_q;
  logic [7:0]              rnd_q;
  logic [ADDR_W-1:0]       waddr_q;
  logic [7:0]              wdata_q;
  logic [ROW_W-1:0]        rsel_q;

  logic [15:0]             ins_q;
  logic [7:0]              v_q [16];
  logic [7:0]              vx_q;
  logic [7:0]              vy_q;
  logic [15:0]             idx_q;
  logic [ADDR_W-1:0]       pc_q;
  logic [ADDR_W-1:0]       stk_q [STACK_DEPTH];
  logic [SP_W-1:0]         sp_q;
  logic [SP_W-1:0]         sp_dec;
  logic [SP_W-1:0]         sp_inc;
  logic [SCNT_W-1:0]       scnt_q;
  logic [SCREEN_WIDTH-1:0] fb_q [SCREEN_HEIGHT];
  logic [7:0]              delay_q;
  logic [7:0]              sound_q;
  logic [7:0]              sound_nxt;
  logic                    hit_q;
  logic                    wait_q;
  logic                    serr_q;

  logic [3:0]              rd_sel;
  logic [7:0]              rd_val;
  logic [3:0]              ins_x;
  logic [3:0]              ins_y;
  logic [7:0]              ins_nn;
  logic [ADDR_W-1:0]       ins_nnn;
  logic [ADDR_W-1:0]       pc_skip;
  logic [ADDR_W-1:0]       idx_addr;

  logic [7:0]              alu_res;
  logic                    alu_flag;
  logic                    alu_wr;
  logic [8:0]              alu_sum;
  logic [3:0]              key_first;
  logic                    key_any;
  logic [11:0]             bcd;
  logic [6:0]              font_ofs5;

  logic [ROW_W-1:0]        spr_row;
  logic [2*SCREEN_WIDTH-1:0] spr_wide;
  logic [SCREEN_WIDTH-1:0] spr_mask;

  logic                    out_valid_q;
  logic [11:0]             out_pc_q;
  logic [63:0]             out_row_q;
  logic                    out_sound_q;
  logic                    out_wait_q;
  logic                    out_serr_q;

  function automatic logic [11:0] to_bcd(input logic [7:0] bin);
    logic [19:0] sh;
    sh = {12'd0, bin};
    for (int i = 0; i < 8; i++) begin
      if (sh[11:8] > 4'd4) sh[11:8] = sh[11:8] + 4'd3;
      if (sh[15:12] > 4'd4) sh[15:12] = sh[15:12] + 4'd3;
      sh = sh << 1;
    end
    return sh[19:8];
  endfunction

  assign ins_x   = ins_q[11:8];
  assign ins_y   = ins_q[7:4];
  assign ins_nn  = ins_q[7:0];
  assign ins_nnn = ins_q[11:0];
  assign pc_skip = pc_q + ADDR_W'(2);
  assign idx_addr = idx_q[ADDR_W-1:0] + ADDR_W'(cmd_i.cnt);
  assign sp_dec  = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - SP_W'(1);
  assign sp_inc  = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + SP_W'(1);
  assign sound_nxt = (op_q == OP_EXEC && sound_q != 8'd0) ? sound_q - 8'd1 : sound_q;
  assign bcd     = to_bcd(vx_q);
  assign font_ofs5 = 7'({vx_q[3:0], 2'b00}) + 7'(vx_q[3:0]);

  always_comb begin
    unique case (cmd_i.op)
      DP_READ_X: rd_sel = ins_x;
      DP_READ_Y: rd_sel = (ins_q[15:12] == 4'hB) ? 4'd0 : ins_y;
      default:   rd_sel = cmd_i.cnt;
    endcase
  end
  assign rd_val = v_q[rd_sel];

  assign font_off  = clr_addr_q - FONT_BASE;
  assign font_byte = (clr_addr_q >= FONT_BASE && clr_addr_q < FONT_BASE + ADDR_W'(FONT_BYTES))
                     ? FONT[font_off[6:0]] : 8'd0;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_addr;
    mem_wdata = rd_val;
    unique case (cmd_i.op)
      DP_CLEAR: begin
        mem_we    = !clr_done_q;
        mem_waddr = clr_addr_q;
        mem_wdata = font_byte;
      end
      DP_DISPATCH: begin
        mem_we    = (op_q == OP_WRITE);
        mem_waddr = waddr_q;
        mem_wdata = wdata_q;
      end
      DP_BCD: begin
        mem_we = 1'b1;
        unique case (cmd_i.cnt[1:0])
          2'd0:    mem_wdata = {4'd0, bcd[11:8]};
          2'd1:    mem_wdata = {4'd0, bcd[7:4]};
          default: mem_wdata = {4'd0, bcd[3:0]};
        endcase
      end
      DP_STORE: mem_we = 1'b1;
      default:  mem_we = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.op)
      DP_FETCH_HI: mem_raddr = pc_q;
      DP_FETCH_LO: mem_raddr = pc_q + ADDR_W'(1);
      default:     mem_raddr = idx_addr;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= mem[mem_raddr];
  end

  always_comb begin
    alu_sum  = {1'b0, vx_q} + {1'b0, vy_q};
    alu_res  = vy_q;
    alu_flag = 1'b0;
    alu_wr   = 1'b0;
    unique case (ins_q[3:0])
      4'h0: begin alu_res = vy_q; end
      4'h1: begin alu_res = vx_q | vy_q; end
      4'h2: begin alu_res = vx_q & vy_q; end
      4'h3: begin alu_res = vx_q ^ vy_q; end
      4'h4: begin alu_res = alu_sum[7:0]; alu_flag = alu_sum[8]; alu_wr = 1'b1; end
      4'h5: begin alu_res = vx_q - vy_q; alu_flag = (vx_q >= vy_q); alu_wr = 1'b1; end
      4'h6: begin alu_res = vx_q >> 1; alu_flag = vx_q[0]; alu_wr = 1'b1; end
      4'h7: begin alu_res = vy_q - vx_q; alu_flag = (vy_q >= vx_q); alu_wr = 1'b1; end
      4'hE: begin alu_res = vx_q << 1; alu_flag = vx_q[7]; alu_wr = 1'b1; end
      default: alu_res = vx_q;
    endcase
  end

  always_comb begin
    key_first = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (keys_q[i]) key_first = 4'(i);
    end
  end
  assign key_any = |keys_q;

  assign spr_row  = vy_q[ROW_W-1:0] + ROW_W'(cmd_i.cnt);
  assign spr_wide = {mem_rdata_q, {(SCREEN_WIDTH-8){1'b0}},
                     mem_rdata_q, {(SCREEN_WIDTH-8){1'b0}}} >> vx_q[COL_W-1:0];
  assign spr_mask = spr_wide[SCREEN_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_done_q <= 1'b0;
    end else if (cmd_i.op == DP_CLEAR && !clr_done_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(MEM_BYTES - 1)) clr_done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LATCH) begin
      op_q    <= in_op_i;
      keys_q  <= in_keys_i;
      rnd_q   <= in_random_byte_i;
      waddr_q <= in_mem_address_i;
      wdata_q <= in_mem_data_i;
      rsel_q  <= in_row_select_i;
    end
    if (cmd_i.op == DP_FETCH_LO) ins_q[15:8] <= mem_rdata_q;
    if (cmd_i.op == DP_DECODE) ins_q[7:0] <= mem_rdata_q;
    if (cmd_i.op == DP_READ_X) vx_q <= rd_val;
    if (cmd_i.op == DP_READ_Y) vy_q <= rd_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) v_q[i] <= 8'd0;
      for (int i = 0; i < STACK_DEPTH; i++) stk_q[i] <= '0;
      for (int i = 0; i < SCREEN_HEIGHT; i++) fb_q[i] <= '0;
      idx_q   <= '0;
      pc_q    <= PC_START;
      sp_q    <= '0;
      scnt_q  <= '0;
      delay_q <= '0;
      sound_q <= '0;
      hit_q   <= 1'b0;
      wait_q  <= 1'b0;
      serr_q  <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        DP_LATCH: begin
          wait_q <= 1'b0;
          serr_q <= 1'b0;
        end
        DP_DECODE: pc_q <= pc_q + ADDR_W'(2);
        DP_EXEC: begin
          hit_q <= 1'b0;
          unique case (ins_q[15:12])
            4'h0: begin
              if (ins_q == 16'h00E0) begin
                for (int i = 0; i < SCREEN_HEIGHT; i++) fb_q[i] <= '0;
              end else if (ins_q == 16'h00EE) begin
                if (scnt_q == '0) serr_q <= 1'b1;
                else scnt_q <= scnt_q - SCNT_W'(1);
                sp_q <= sp_dec;
                pc_q <= stk_q[sp_dec];
              end
            end
            4'h1: pc_q <= ins_nnn;
            4'h2: begin
              if (scnt_q >= SCNT_W'(STACK_DEPTH)) serr_q <= 1'b1;
              else scnt_q <= scnt_q + SCNT_W'(1);
              stk_q[sp_q] <= pc_q;
              sp_q <= sp_inc;
              pc_q <= ins_nnn;
            end
            4'h3: if (vx_q == ins_nn) pc_q <= pc_skip;
            4'h4: if (vx_q != ins_nn) pc_q <= pc_skip;
            4'h5: if (ins_q[3:0] == 4'h0 && vx_q == vy_q) pc_q <= pc_skip;
            4'h6: v_q[ins_x] <= ins_nn;
            4'h7: v_q[ins_x] <= vx_q + ins_nn;
            4'h8: begin
              v_q[ins_x] <= alu_res;
              if (alu_wr) v_q[15] <= {7'd0, alu_flag};
            end
            4'h9: if (ins_q[3:0] == 4'h0 && vx_q != vy_q) pc_q <= pc_skip;
            4'hA: idx_q <= {4'd0, ins_nnn};
            4'hB: pc_q <= ins_nnn + ADDR_W'(vy_q);
            4'hC: v_q[ins_x] <= rnd_q & ins_nn;
            4'hD: hit_q <= 1'b0;
            4'hE: begin
              if ((ins_nn == 8'h9E && keys_q[vx_q[3:0]]) ||
                  (ins_nn == 8'hA1 && !keys_q[vx_q[3:0]])) pc_q <= pc_skip;
            end
            default: begin
              unique case (ins_nn)
                8'h07: v_q[ins_x] <= delay_q;
                8'h0A: begin
                  if (key_any) begin
                    v_q[ins_x] <= {4'd0, key_first};
                  end else begin
                    pc_q   <= pc_q - ADDR_W'(2);
                    wait_q <= 1'b1;
                  end
                end
                8'h15: delay_q <= vx_q;
                8'h18: sound_q <= vx_q;
                8'h1E: idx_q <= idx_q + {8'd0, vx_q};
                8'h29: idx_q <= {4'd0, FONT_BASE} + {9'd0, font_ofs5};
                default: idx_q <= idx_q;
              endcase
            end
          endcase
        end
        DP_SPR_WR: begin
          if (|(fb_q[spr_row] & spr_mask)) hit_q <= 1'b1;
          fb_q[spr_row] <= fb_q[spr_row] ^ spr_mask;
        end
        DP_SPR_END: v_q[15] <= {7'd0, hit_q};
        DP_LOAD_WR: v_q[cmd_i.cnt] <= mem_rdata_q;
        DP_FINISH: begin
          if (op_q == OP_EXEC && delay_q != 8'd0) delay_q <= delay_q - 8'd1;
          sound_q <= sound_nxt;
        end
        default: hit_q <= hit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_FINISH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_FINISH) begin
      out_pc_q    <= pc_q;
      out_row_q   <= (op_q == OP_ROW) ? fb_q[rsel_q] : 64'd0;
      out_sound_q <= (sound_nxt != 8'd0);
      out_wait_q  <= wait_q;
      out_serr_q  <= serr_q;
    end
  end

  assign stat_o.clear_done = clr_done_q;
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;
  assign stat_o.op         = op_q;
  assign stat_o.ins        = ins_q;

  assign out_valid_o           = out_valid_q;
  assign out_program_counter_o = out_pc_q;
  assign out_row_pixels_o      = out_row_q;
  assign out_sound_on_o        = out_sound_q;
  assign out_waiting_key_o     = out_wait_q;
  assign out_stack_error_o     = out_serr_q;

  `C8E_ASSERT(a_stack_count, scnt_q <= SCNT_W'(STACK_DEPTH), "Stack count exceeds depth.")
  `C8E_ASSERT_NEXT(a_finish_valid, cmd_i.op == DP_FINISH, out_valid_q, "Result not presented.")
  `C8E_ASSERT_NEXT(a_clear_done, clr_done_q, clr_done_q, "Clearing pass restarted.")
  `C8E_ASSERT(a_no_finish_busy, !(cmd_i.op == DP_FINISH && stat_o.out_busy),
    "Result overwritten while still pending.")

endmodule

>>> src/chip8_instruction_executor.sv
// From acceptance to result: a memory write or row read is dispatched and finished, while an
// instruction is fetched byte by byte, decoded, reads two registers and executes; a sprite then
// reads and draws each row and sets VF, BCD writes three digits, register store writes x + 1
// bytes and register load reads x + 1 bytes. One request is in flight at a time;
// the input is ready again as the result is presented, and the result register frees it.
// After reset a clearing pass loads the font and zeroes memory.
// ---------------------------------------------------------------------------
// CHIP-8 instruction executor
// Top level: joins the controller and the datapath to the stream ports.
// ---------------------------------------------------------------------------
module chip8_instruction_executor
  import c8e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // keys[15:0], random_byte[23:16], mem_address[35:24], mem_data[43:36],
  // row_select[48:44], zero fill
  input  logic [55:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // program_counter[11:0], row_pixels[75:12], sound_on[76], waiting_key[77],
  // stack_error[78], zero fill
  output logic [79:0] m_axis_tdata
);

  cmd_t        cmd;
  stat_t       stat;
  logic [11:0] pc;
  logic [63:0] row;
  logic        snd;
  logic        wkey;
  logic        serr;

  c8e_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  c8e_datapath u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .in_op_i               (s_axis_tuser),
    .in_keys_i             (s_axis_tdata[15:0]),
    .in_random_byte_i      (s_axis_tdata[23:16]),
    .in_mem_address_i      (s_axis_tdata[35:24]),
    .in_mem_data_i         (s_axis_tdata[43:36]),
    .in_row_select_i       (s_axis_tdata[48:44]),
    .out_valid_o           (m_axis_tvalid),
    .out_ready_i           (m_axis_tready),
    .out_program_counter_o (pc),
    .out_row_pixels_o      (row),
    .out_sound_on_o        (snd),
    .out_waiting_key_o     (wkey),
    .out_stack_error_o     (serr)
  );

  assign m_axis_tdata = {1'b0, serr, wkey, snd, row, pc};

endmodule

>>> dv/chip8_instruction_executor_test.sv
// ---------------------------------------------------------------------------
// CHIP-8 instruction executor testbench
// Loads short programs into memory and executes them through the stream
// ports. A behavioral machine model predicts every result, and each result
// is compared field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module chip8_instruction_executor_test;
  import c8e_pkg::*;

  typedef struct packed {
    logic [11:0] pc;
    logic [63:0] row;
    logic        snd;
    logic        wait_k;
    logic        serr;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;

  chip8_instruction_executor u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  logic [7:0]  mach_mem [MEM_BYTES];
  logic [7:0]  mach_v [16];
  logic [15:0] mach_i;
  logic [11:0] mach_pc;
  logic [11:0] mach_stack [STACK_DEPTH];
  logic [3:0]  mach_sp;
  int          mach_depth;
  logic [63:0] mach_fb [SCREEN_HEIGHT];
  logic [7:0]  mach_delay;
  logic [7:0]  mach_sound;

  outcome_t pending_results [$];
  int       error_count;
  int       result_count;
  int       sent_count;
  int       exec_count;
  bit       idle_enable;
  bit       hold_off;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #400000000;
    $display("chip8_instruction_executor_test: done, errors");
    $finish;
  end

  function automatic void machine_reset();
    for (int a = 0; a < MEM_BYTES; a++) mach_mem[a] = 8'h00;
    for (int a = 0; a < FONT_BYTES; a++) mach_mem[FONT_BASE + a] = FONT[a];
    for (int r = 0; r < 16; r++) mach_v[r] = 8'h00;
    for (int r = 0; r < STACK_DEPTH; r++) mach_stack[r] = 12'h000;
    for (int r = 0; r < SCREEN_HEIGHT; r++) mach_fb[r] = 64'h0;
    mach_i = 16'h0;
    mach_pc = PC_START;
    mach_sp = 4'h0;
    mach_depth = 0;
    mach_delay = 8'h00;
    mach_sound = 8'h00;
  endfunction

  function automatic void machine_execute(logic [15:0] keys, logic [7:0] rnd,
                                          ref outcome_t res);
    logic [15:0] ins;
    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy, flag, bits;
    logic [11:0] nnn;
    logic [8:0]  wide;
    int          key;
    bit          hit;
    ins = {mach_mem[mach_pc], mach_mem[12'(mach_pc + 12'd1)]};
    x = ins[11:8];
    y = ins[7:4];
    n = ins[3:0];
    nn = ins[7:0];
    nnn = ins[11:0];
    mach_pc = mach_pc + 12'd2;
    vx = mach_v[x];
    vy = mach_v[y];
    case (ins[15:12])
      4'h0: begin
        if (ins == 16'h00E0) begin
          for (int r = 0; r < SCREEN_HEIGHT; r++) mach_fb[r] = 64'h0;
        end else if (ins == 16'h00EE) begin
          if (mach_depth == 0) res.serr = 1'b1;
          else mach_depth--;
          mach_sp = mach_sp - 4'd1;
          mach_pc = mach_stack[mach_sp];
        end
      end
      4'h1: mach_pc = nnn;
      4'h2: begin
        if (mach_depth >= STACK_DEPTH) res.serr = 1'b1;
        else mach_depth++;
        mach_stack[mach_sp] = mach_pc;
        mach_sp = mach_sp + 4'd1;
        mach_pc = nnn;
      end
      4'h3: if (vx == nn) mach_pc = mach_pc + 12'd2;
      4'h4: if (vx != nn) mach_pc = mach_pc + 12'd2;
      4'h5: if (n == 4'h0 && vx == vy) mach_pc = mach_pc + 12'd2;
      4'h6: mach_v[x] = nn;
      4'h7: mach_v[x] = vx + nn;
      4'h8: begin
        case (n)
          4'h0: mach_v[x] = vy;
          4'h1: mach_v[x] = vx | vy;
          4'h2: mach_v[x] = vx & vy;
          4'h3: mach_v[x] = vx ^ vy;
          4'h4: begin
            wide = {1'b0, vx} + {1'b0, vy};
            mach_v[x] = wide[7:0];
            mach_v[15] = {7'b0, wide[8]};
          end
          4'h5: begin
            flag = {7'b0, vx >= vy};
            mach_v[x] = vx - vy;
            mach_v[15] = flag;
          end
          4'h6: begin
            mach_v[x] = vx >> 1;
            mach_v[15] = {7'b0, vx[0]};
          end
          4'h7: begin
            flag = {7'b0, vy >= vx};
            mach_v[x] = vy - vx;
            mach_v[15] = flag;
          end
          4'hE: begin
            mach_v[x] = vx << 1;
            mach_v[15] = {7'b0, vx[7]};
          end
          default: ;
        endcase
      end
      4'h9: if (n == 4'h0 && vx != vy) mach_pc = mach_pc + 12'd2;
      4'hA: mach_i = {4'h0, nnn};
      4'hB: mach_pc = nnn + {4'h0, mach_v[0]};
      4'hC: mach_v[x] = rnd & nn;
      4'hD: begin
        hit = 1'b0;
        for (int r = 0; r < n; r++) begin
          bits = mach_mem[12'(mach_i + r)];
          for (int c = 0; c < 8; c++) begin
            if (bits[7 - c]) begin
              int row_i, col;
              row_i = (vy + r) % SCREEN_HEIGHT;
              col = (vx + c) % SCREEN_WIDTH;
              if (mach_fb[row_i][63 - col]) hit = 1'b1;
              mach_fb[row_i][63 - col] = ~mach_fb[row_i][63 - col];
            end
          end
        end
        mach_v[15] = {7'b0, hit};
      end
      4'hE: begin
        if ((nn == 8'h9E && keys[vx[3:0]]) || (nn == 8'hA1 && !keys[vx[3:0]]))
          mach_pc = mach_pc + 12'd2;
      end
      default: begin
        case (nn)
          8'h07: mach_v[x] = mach_delay;
          8'h0A: begin
            key = -1;
            for (int k = 15; k >= 0; k--) if (keys[k]) key = k;
            if (key >= 0) mach_v[x] = 8'(key);
            else begin
              mach_pc = mach_pc - 12'd2;
              res.wait_k = 1'b1;
            end
          end
          8'h15: mach_delay = vx;
          8'h18: mach_sound = vx;
          8'h1E: mach_i = mach_i + {8'h0, vx};
          8'h29: mach_i = {4'h0, FONT_BASE} + 16'(5 * vx[3:0]);
          8'h33: begin
            mach_mem[mach_i[11:0]] = 8'(vx / 100);
            mach_mem[12'(mach_i + 1)] = 8'((vx / 10) % 10);
            mach_mem[12'(mach_i + 2)] = 8'(vx % 10);
          end
          8'h55: for (int r = 0; r <= x; r++) mach_mem[12'(mach_i + r)] = mach_v[r];
          8'h65: for (int r = 0; r <= x; r++) mach_v[r] = mach_mem[12'(mach_i + r)];
          default: ;
        endcase
      end
    endcase
    if (mach_sound != 0) mach_sound--;
    if (mach_delay != 0) mach_delay--;
  endfunction

  function automatic outcome_t predict_outcome(logic [1:0] op, logic [55:0] data);
    outcome_t res;
    res = '0;
    if (op == OP_EXEC) machine_execute(data[15:0], data[23:16], res);
    else if (op == OP_WRITE) mach_mem[data[35:24]] = data[43:36];
    else if (op == OP_ROW) res.row = mach_fb[data[48:44]];
    res.pc = mach_pc;
    res.snd = (mach_sound != 0);
    return res;
  endfunction

  task automatic send_request(logic [1:0] op, logic [15:0] keys, logic [7:0] rnd,
                              logic [11:0] addr, logic [7:0] wdata, logic [4:0] row);
    logic [55:0] data;
    data = {7'b0, row, wdata, addr, rnd, keys};
    while (idle_enable && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_outcome(op, data));
    sent_count++;
    if (op == OP_EXEC) exec_count++;
  endtask

  task automatic write_byte(logic [11:0] addr, logic [7:0] b);
    send_request(OP_WRITE, 16'($urandom), 8'($urandom), addr, b, 5'($urandom));
  endtask

  task automatic write_word(logic [11:0] addr, logic [15:0] w);
    write_byte(addr, w[15:8]);
    write_byte(addr + 12'd1, w[7:0]);
  endtask

  task automatic run_ins(logic [15:0] keys);
    send_request(OP_EXEC, keys, 8'($urandom), 12'($urandom), 8'($urandom),
                 5'($urandom));
  endtask

  task automatic read_row(logic [4:0] row);
    send_request(OP_ROW, 16'($urandom), 8'($urandom), 12'($urandom), 8'($urandom),
                 row);
  endtask

  // Places an instruction at the current program counter and runs it.
  task automatic run_word(logic [15:0] w, logic [15:0] keys);
    write_word(mach_pc, w);
    run_ins(keys);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      outcome_t got, want;
      got = {m_axis_tdata[11:0], m_axis_tdata[75:12], m_axis_tdata[76],
             m_axis_tdata[77], m_axis_tdata[78]};
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.pc !== want.pc) begin
          $display("%0t: pc expected %h actual %h", $time, want.pc, got.pc);
          error_count++;
        end
        if (got.row !== want.row) begin
          $display("%0t: row expected %h actual %h", $time, want.row, got.row);
          error_count++;
        end
        if (got.snd !== want.snd) begin
          $display("%0t: sound expected %b actual %b", $time, want.snd, got.snd);
          error_count++;
        end
        if (got.wait_k !== want.wait_k) begin
          $display("%0t: key wait expected %b actual %b", $time, want.wait_k,
                   got.wait_k);
          error_count++;
        end
        if (got.serr !== want.serr) begin
          $display("%0t: stack error expected %b actual %b", $time, want.serr,
                   got.serr);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (idle_enable) m_axis_tready <= ($urandom_range(99) >= 27);
    else m_axis_tready <= 1'b1;
  end

  task automatic test_directed();
    write_word(12'h200, 16'h60FF);
    write_word(12'h202, 16'h61FF);
    for (int k = 0; k < 2; k++) run_ins(16'h0000);
    run_word(16'h8014, 16'h0000);
    run_word(16'h8015, 16'h0000);
    run_word(16'h801E, 16'h0000);
    run_word(16'h8F16, 16'h0000);
    run_word(16'h8F17, 16'h0000);
    run_word(16'hA000, 16'h0000);
    run_word(16'hF029, 16'h0000);
    run_word(16'hD00F, 16'h0000);
    read_row(5'd0);
    read_row(5'd31);
    run_word(16'hF00A, 16'h0000);
    run_ins(16'h8000);
    run_word(16'hE09E, 16'hFFFF);
    run_word(16'h00EE, 16'h0000);
    run_word(16'hCFAA, 16'h0000);
    run_word(16'h6F3F, 16'h0000);
    run_word(16'hDFFF, 16'h0000);
    read_row(5'd1);
    run_word(16'h00E0, 16'h0000);
  endtask

  // Fills every instruction slot with a legal or near-legal random opcode.
  function automatic logic [15:0] random_word();
    logic [15:0] w;
    logic [7:0]  fsub [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33,
                               8'h55, 8'h65};
    logic [3:0]  asub [10] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
                               4'hE, 4'h9};
    w = 16'($urandom);
    case (w[15:12])
      4'h0: w = ($urandom_range(3) == 0) ? w & 16'h0FFF :
                ($urandom_range(1) ? 16'h00EE : 16'h00E0);
      4'h1, 4'h2, 4'hB: w[11:9] = 3'b001 | 3'($urandom_range(1) << 1);
      4'h8: if ($urandom_range(7) != 0) w[3:0] = asub[$urandom_range(9)];
      4'hE: if ($urandom_range(7) != 0) w[7:0] = $urandom_range(1) ? 8'h9E : 8'hA1;
      4'hF: if ($urandom_range(7) != 0) w[7:0] = fsub[$urandom_range(8)];
      4'hD: w[3:0] = 4'($urandom_range(4));
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_random_programs(int items);
    int done_items;
    logic [11:0] pc_seen;
    done_items = 0;
    while (done_items < items) begin
      case ($urandom_range(19))
        0: begin
          write_byte(12'($urandom), 8'($urandom));
          done_items++;
        end
        1: begin
          read_row(5'($urandom));
          done_items++;
        end
        default: begin
          pc_seen = mach_pc;
          write_word(pc_seen, random_word());
          run_ins($urandom_range(3) == 0 ? 16'h0000 : 16'(1 << $urandom_range(15)) |
                  16'($urandom & $urandom));
          done_items += 3;
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 30; k++) read_row(5'(k));
    join
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_EXEC;
    m_axis_tready = 1'b0;
    error_count = 0;
    result_count = 0;
    sent_count = 0;
    exec_count = 0;
    idle_enable = 1'b0;
    hold_off = 1'b0;
    machine_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    idle_enable = 1'b1;
    test_random_programs(700);
    test_backpressure();
    idle_enable = 1'b0;
    test_random_programs(200);
    idle_enable = 1'b1;
    test_random_programs(500);
    wait_drain();
    $display("Covered %0d requests, %0d instruction executions, %0d results checked.",
             sent_count, exec_count, result_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("chip8_instruction_executor_test: done, clean");
    end else begin
      $display("chip8_instruction_executor_test: done, errors");
    end
    $finish;
  end

endmodule
